@@ design/bmp_rle8_pkg.sv @@
// Shared types and constants for the 8-bit bitmap pixel-data decoder.
package bmp_rle8_pkg;

  localparam int DATA_W    = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W    = 24;
  localparam int OUT_W     = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // Second byte of an escape pair (first byte zero)
  localparam logic [DATA_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [DATA_W-1:0] ESC_EOB   = 8'd1;
  localparam logic [DATA_W-1:0] ESC_DELTA = 8'd2;

  // Parser phase of the compressed stream
  typedef enum logic [2:0] {
    PH_CMD,
    PH_CODE,
    PH_DX,
    PH_DY,
    PH_LIT,
    PH_PAD,
    PH_DONE
  } phase_t;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL_RST,
    OP_LOAD_RST,
    OP_STEP,
    OP_DY_SUB,
    OP_RUN,
    OP_FIN
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RST,
    S_STEP,
    S_DY,
    S_RUN,
    S_FIN
  } ctl_state_t;

  // Status from datapath to controller
  typedef struct packed {
    logic phase_done;
    logic rst_neg;
    logic step_run;
    logic step_dy;
    logic run_last;
    logic run_stall;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ design/bmp_rle8_ctrl.sv @@
// Sequencer that steps the datapath through one input byte at a time.
module bmp_rle8_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_first,
  input  bmp_rle8_pkg::dp_stat_t  stat,
  output logic                    in_ready,
  output bmp_rle8_pkg::dp_op_t    op
);
  import bmp_rle8_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_first) begin
            state_nxt = S_MUL;
          end else if (!stat.phase_done) begin
            state_nxt = S_STEP;
          end
        end
      end
      S_MUL: state_nxt = S_RST;
      S_RST: begin
        // zero height ends at once: skip decoding the byte
        state_nxt = stat.rst_neg ? S_FIN : S_STEP;
      end
      S_STEP: begin
        if (stat.step_run) begin
          state_nxt = S_RUN;
        end else if (stat.step_dy) begin
          state_nxt = S_DY;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DY: state_nxt = S_FIN;
      S_RUN: begin
        if (!stat.run_stall && stat.run_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        op       = in_valid ? OP_LATCH : OP_NONE;
      end
      S_MUL:  op = OP_MUL_RST;
      S_RST:  op = OP_LOAD_RST;
      S_STEP: op = OP_STEP;
      S_DY:   op = OP_DY_SUB;
      S_RUN:  op = stat.run_stall ? OP_NONE : OP_RUN;
      S_FIN:  op = stat.out_busy ? OP_NONE : OP_FIN;
      default: op = OP_NONE;
    endcase
  end

endmodule

@@ design/bmp_rle8_dp.sv @@
// Decoder datapath: configuration, parser state, segment builder, output register.
module bmp_rle8_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bmp_rle8_pkg::dp_op_t                   op,
  output bmp_rle8_pkg::dp_stat_t                 stat,
  input  logic [bmp_rle8_pkg::DATA_W-1:0]        in_byte,
  input  logic                                   in_final,
  input  logic                                   cfg_valid,
  input  logic [bmp_rle8_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmp_rle8_pkg::CFG_W-1:0]         cfg_data,
  output logic [bmp_rle8_pkg::OUT_W-1:0]         out_data,
  output logic                                   out_done,
  output logic                                   out_last,
  output logic                                   out_valid,
  input  logic                                   out_ready
);
  import bmp_rle8_pkg::*;

  localparam int CapW = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int CapH = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
  localparam logic [CFG_W-1:0] CAP_W = CapW[CFG_W-1:0];
  localparam logic [CFG_W-1:0] CAP_H = CapH[CFG_W-1:0];
  localparam logic [CFG_W-1:0] MIN_W = 13'd8;

  localparam logic [15:0] COL_MAX = 16'hFFFF;

  // configuration
  logic [CFG_W-1:0] width_r, height_r;
  logic             rle_r;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic [7:0]          first_code_r, first_code_nxt;
  logic [7:0]          pend_r, pend_nxt;
  logic signed [26:0]  rbase_r, rbase_nxt;
  logic [15:0]         col_r, col_nxt;
  logic                jw_r, jw_nxt;
  logic                pad_r, pad_nxt;
  logic                eob_r, eob_nxt;
  logic                final_r, final_nxt;

  // work registers
  logic [7:0]          byte_r, byte_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic signed [26:0]  prod_r, prod_nxt;

  // pending segment, held back one step so its last flag is known
  logic                pv_r, pv_nxt;
  logic [ADDR_W-1:0]   paddr_r, paddr_nxt;
  logic [7:0]          plen_r, plen_nxt;

  // output register
  logic                ov_r, ov_nxt;
  logic [ADDR_W-1:0]   oaddr_r, oaddr_nxt;
  logic [7:0]          olen_r, olen_nxt;
  logic [7:0]          ocol_r, ocol_nxt;
  logic                odone_r, odone_nxt;
  logic                olast_r, olast_nxt;

  logic [CFG_W-1:0]    eff_w, eff_h;
  logic signed [26:0]  w_s;
  logic signed [13:0]  h_m1, mul_b;
  logic signed [27:0]  mul_p;
  logic [13:0]         scan;
  logic [15:0]         col_inc, col_run;
  logic [16:0]         col_sum;
  logic                col_ge_w, rb_neg, out_busy, in_image;
  logic [CFG_W-1:0]    room;
  logic                rem_fits;
  logic [7:0]          chunk;
  logic [ADDR_W-1:0]   cur_addr;
  logic                ending;

  always_comb begin
    eff_w = (width_r < MIN_W) ? MIN_W : ((width_r > CAP_W) ? CAP_W : width_r);
    eff_h = (height_r > CAP_H) ? CAP_H : height_r;
    w_s   = $signed({14'd0, eff_w});
    h_m1  = $signed({1'b0, eff_h}) - 14'sd1;
    mul_b = (op == OP_MUL_RST) ? h_m1 : $signed({6'd0, byte_r});
    mul_p = $signed({1'b0, eff_w}) * mul_b;
    scan  = ({1'b0, eff_w} + 14'd3) & 14'h3FFC;

    col_inc  = (col_r == COL_MAX) ? col_r : col_r + 16'd1;
    col_sum  = {1'b0, col_r} + {9'd0, byte_r};
    col_ge_w = (col_r >= {3'd0, eff_w});
    rb_neg   = rbase_r[26];
    in_image = !rb_neg && !col_ge_w;
    cur_addr = rbase_r[ADDR_W-1:0] + {8'd0, col_r};
    out_busy = ov_r && !out_ready;

    room     = eff_w - col_r[CFG_W-1:0];
    rem_fits = ({5'd0, rem_r} <= room);
    chunk    = rem_fits ? rem_r : room[7:0];
    col_run  = col_r + {8'd0, chunk};
    ending   = eob_r || final_r || rb_neg;
  end

  always_comb begin
    stat.phase_done = (phase_r == PH_DONE);
    stat.rst_neg    = prod_r[26];
    stat.step_run   = rle_r && (phase_r == PH_CODE) && (first_code_r != 8'd0);
    stat.step_dy    = rle_r && (phase_r == PH_DY);
    stat.run_last   = col_ge_w ? (rem_r == 8'd1) : rem_fits;
    stat.run_stall  = !col_ge_w && !rb_neg && pv_r && out_busy;
    stat.out_busy   = out_busy;
  end

  always_comb begin
    phase_nxt      = phase_r;
    first_code_nxt = first_code_r;
    pend_nxt       = pend_r;
    rbase_nxt      = rbase_r;
    col_nxt        = col_r;
    jw_nxt         = jw_r;
    pad_nxt        = pad_r;
    eob_nxt        = eob_r;
    final_nxt      = final_r;
    byte_nxt       = byte_r;
    rem_nxt        = rem_r;
    prod_nxt       = prod_r;
    pv_nxt         = pv_r;
    paddr_nxt      = paddr_r;
    plen_nxt       = plen_r;
    ov_nxt         = ov_r && !out_ready;
    oaddr_nxt      = oaddr_r;
    olen_nxt       = olen_r;
    ocol_nxt       = ocol_r;
    odone_nxt      = odone_r;
    olast_nxt      = olast_r;

    case (op)
      OP_LATCH: begin
        byte_nxt  = in_byte;
        final_nxt = in_final;
        eob_nxt   = 1'b0;
      end
      OP_MUL_RST: begin
        prod_nxt = mul_p[26:0];
      end
      OP_LOAD_RST: begin
        rbase_nxt      = prod_r;
        col_nxt        = 16'd0;
        phase_nxt      = PH_CMD;
        first_code_nxt = 8'd0;
        pend_nxt       = 8'd0;
        jw_nxt         = 1'b0;
        pad_nxt        = 1'b0;
      end
      OP_STEP: begin
        prod_nxt = mul_p[26:0];
        if (!rle_r) begin
          // raw row copy, at most one segment per byte
          if (in_image) begin
            pv_nxt    = 1'b1;
            paddr_nxt = cur_addr;
            plen_nxt  = 8'd1;
          end
          if (col_inc >= {2'd0, scan}) begin
            col_nxt   = 16'd0;
            rbase_nxt = rbase_r - w_s;
          end else begin
            col_nxt = col_inc;
          end
        end else begin
          case (phase_r)
            PH_CMD: begin
              first_code_nxt = byte_r;
              phase_nxt      = PH_CODE;
            end
            PH_CODE: begin
              phase_nxt = PH_CMD;
              if (first_code_r != 8'd0) begin
                rem_nxt = first_code_r;
              end else if (byte_r == ESC_EOL) begin
                // skip end-of-line right after a wrap
                if (!jw_r) begin
                  col_nxt   = 16'd0;
                  rbase_nxt = rbase_r - w_s;
                end
              end else if (byte_r == ESC_EOB) begin
                eob_nxt = 1'b1;
              end else if (byte_r == ESC_DELTA) begin
                phase_nxt = PH_DX;
              end else begin
                pend_nxt  = byte_r;
                pad_nxt   = byte_r[0];
                phase_nxt = PH_LIT;
              end
            end
            PH_DX: begin
              col_nxt   = col_sum[16] ? COL_MAX : col_sum[15:0];
              phase_nxt = PH_DY;
            end
            PH_DY: begin
              phase_nxt = PH_CMD;
            end
            PH_LIT: begin
              if (in_image) begin
                pv_nxt    = 1'b1;
                paddr_nxt = cur_addr;
                plen_nxt  = 8'd1;
              end
              if (col_inc >= {3'd0, eff_w}) begin
                col_nxt   = 16'd0;
                rbase_nxt = rbase_r - w_s;
                jw_nxt    = 1'b1;
              end else begin
                col_nxt = col_inc;
                jw_nxt  = 1'b0;
              end
              pend_nxt = (pend_r != 8'd0) ? pend_r - 8'd1 : pend_r;
              if (pend_nxt == 8'd0) begin
                phase_nxt = pad_r ? PH_PAD : PH_CMD;
              end
            end
            default: phase_nxt = PH_CMD;
          endcase
        end
      end
      OP_DY_SUB: begin
        rbase_nxt = rbase_r - prod_r;
      end
      OP_RUN: begin
        if (col_ge_w) begin
          // pixel off the right edge: drop it and wrap
          col_nxt   = 16'd0;
          rbase_nxt = rbase_r - w_s;
          jw_nxt    = 1'b1;
          rem_nxt   = rem_r - 8'd1;
        end else begin
          if (!rb_neg) begin
            if (pv_r) begin
              ov_nxt    = 1'b1;
              oaddr_nxt = paddr_r;
              olen_nxt  = plen_r;
              ocol_nxt  = byte_r;
              odone_nxt = 1'b0;
              olast_nxt = 1'b0;
            end
            pv_nxt    = 1'b1;
            paddr_nxt = cur_addr;
            plen_nxt  = chunk;
          end
          if (col_run == {3'd0, eff_w}) begin
            col_nxt   = 16'd0;
            rbase_nxt = rbase_r - w_s;
            jw_nxt    = 1'b1;
          end else begin
            col_nxt = col_run;
            jw_nxt  = 1'b0;
          end
          rem_nxt = rem_r - chunk;
        end
      end
      OP_FIN: begin
        pv_nxt = 1'b0;
        if (pv_r) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = paddr_r;
          olen_nxt  = plen_r;
          ocol_nxt  = byte_r;
          odone_nxt = ending;
          olast_nxt = 1'b1;
        end else if (ending) begin
          // end marker
          ov_nxt    = 1'b1;
          oaddr_nxt = '0;
          olen_nxt  = 8'd0;
          ocol_nxt  = 8'd0;
          odone_nxt = 1'b1;
          olast_nxt = 1'b1;
        end
        if (ending) begin
          phase_nxt = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd8;
      height_r <= 13'd1;
      rle_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_MODE:   rle_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      first_code_r <= 8'd0;
      pend_r       <= 8'd0;
      rbase_r      <= '0;
      col_r        <= 16'd0;
      jw_r         <= 1'b0;
      pad_r        <= 1'b0;
      eob_r        <= 1'b0;
      final_r      <= 1'b0;
      pv_r         <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      first_code_r <= first_code_nxt;
      pend_r       <= pend_nxt;
      rbase_r      <= rbase_nxt;
      col_r        <= col_nxt;
      jw_r         <= jw_nxt;
      pad_r        <= pad_nxt;
      eob_r        <= eob_nxt;
      final_r      <= final_nxt;
      pv_r         <= pv_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    rem_r   <= rem_nxt;
    prod_r  <= prod_nxt;
    paddr_r <= paddr_nxt;
    plen_r  <= plen_nxt;
    oaddr_r <= oaddr_nxt;
    olen_r  <= olen_nxt;
    ocol_r  <= ocol_nxt;
    odone_r <= odone_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = {ocol_r, olen_r, oaddr_r};
  assign out_done  = odone_r;
  assign out_last  = olast_r;

endmodule

@@ design/bmp_rle8_pixel_decoder.sv @@
// Top level of the 8-bit bitmap pixel-data decoder (raw and RLE8 rows).
//
// Feed the pixel-data bytes on the in_ stream: in_tuser marks the byte that
// restarts decoding at the bottom row, in_tlast the last byte available.
// Each byte yields zero or more fill segments on the out_ stream; out_tlast
// flags the last segment of a byte and out_tuser the one that ends the image.
// Write width, height and mode over cfg_ only while the block is idle.
//
// Bytes are decoded one at a time. An ordinary byte passes the accept,
// decode and finish steps: its segment enters the output register at the
// finish step, and the next byte can be taken once that step is done. A
// restart byte adds multiply and load steps for the shared multiplier that
// forms the bottom row base, a delta row byte adds a row subtraction step.
// An encoded run takes a run step per row it touches, a dropped pixel past
// the row end included. A single output register holds a finished segment;
// a new byte is accepted while it waits. A run step holds once a second
// segment is ready, and the finish step waits until the register is free.
// Reset returns to width 8, height 1, raw mode, bottom row, column zero,
// with no output pending.
module bmp_rle8_pixel_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tuser,   // first_byte
  input  logic                                in_tlast,   // final_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [23:0] start_address, [31:24] fill_length, [39:32] color_index
  output logic [bmp_rle8_pkg::OUT_W-1:0]      out_tdata,
  output logic                                out_tuser,  // image_done
  output logic                                out_tlast,  // last_of_run
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmp_rle8_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmp_rle8_pkg::CFG_W-1:0]      cfg_data
);
  import bmp_rle8_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bmp_rle8_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_first (in_tuser),
    .stat     (stat),
    .in_ready (in_tready),
    .op       (op)
  );

  bmp_rle8_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_byte   (in_tdata),
    .in_final  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_tdata),
    .out_done  (out_tuser),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

endmodule

@@ design/bmp_rle8_chk.sv @@
// Port-level checks for the decoder, bound to the top level.
module bmp_rle8_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // reset empties the output and reopens the input
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input blocked after reset");

  // a restart byte keeps the input closed while the row base is formed
  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken right after a restart transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // only the end marker has zero length
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:24] == 8'd0 |-> out_tuser && out_tlast)
    else $error("zero-length segment that is not an end marker");

endmodule

bind bmp_rle8_pixel_decoder bmp_rle8_chk u_chk (.*);

@@ test/bmp_rle8_pixel_decoder_tb.sv @@
// Self-checking testbench for the bitmap pixel-data decoder, raw and RLE8 streams.
`timescale 1ns / 100ps

module bmp_rle8_pixel_decoder_tb;
  import bmp_rle8_pkg::*;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_SEGS      = 33;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 48;
  localparam int SINK_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    bit [23:0] addr;
    bit [7:0]  len;
    bit [7:0]  color;
    bit        done;
    bit        last;
  } fill_t;

  // Predicts the fill segments of each accepted byte and checks them in order
  class fill_scoreboard;
    bit [CFG_W-1:0] width_cfg;
    bit [CFG_W-1:0] height_cfg;
    bit             rle_cfg;

    phase_t      phase;
    bit [7:0]    first_code;
    bit [7:0]    pending_count;
    longint      row_base;
    int unsigned column;
    bit          just_wrapped;
    bit          pad_pending;

    longint      seg_addr [MAX_SEGS];
    int unsigned seg_len [MAX_SEGS];
    bit [7:0]    seg_color [MAX_SEGS];
    int          seg_count;

    fill_t expected_fills[$];
    int    errors;

    function new();
      width_cfg  = 8;
      height_cfg = 1;
      rle_cfg    = 0;
      errors     = 0;
      restart();
    endfunction

    function int unsigned clamped_width();
      int unsigned w;
      w = width_cfg;
      if (w < 8) w = 8;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned clamped_height();
      int unsigned h;
      h = height_cfg;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
      case (idx)
        REG_WIDTH:  width_cfg = val;
        REG_HEIGHT: height_cfg = val;
        REG_MODE:   rle_cfg = val[0];
        default: ;
      endcase
    endfunction

    function void restart();
      row_base      = longint'(clamped_width()) * (longint'(clamped_height()) - 1);
      column        = 0;
      phase         = PH_CMD;
      first_code    = 0;
      pending_count = 0;
      just_wrapped  = 0;
      pad_pending   = 0;
    endfunction

    function void advance_column();
      if (column < 32'hFFFF) column++;
    endfunction

    // Drop pixels outside the image; merge into the open segment when allowed
    function void add_pixel(bit [7:0] color, bit merge);
      longint addr;
      int k;
      if (row_base < 0 || column >= clamped_width()) return;
      addr = row_base + longint'(column);
      if (merge && seg_count > 0) begin
        k = seg_count - 1;
        if (seg_color[k] == color && seg_addr[k] + longint'(seg_len[k]) == addr &&
            seg_len[k] < 255) begin
          seg_len[k]++;
          return;
        end
      end
      if (seg_count < MAX_SEGS) begin
        seg_addr[seg_count]  = addr;
        seg_len[seg_count]   = 1;
        seg_color[seg_count] = color;
        seg_count++;
      end
    endfunction

    function void rle_pixel(bit [7:0] color, bit merge);
      int unsigned w;
      w = clamped_width();
      add_pixel(color, merge);
      advance_column();
      if (column >= w) begin
        column = 0;
        row_base -= longint'(w);
        just_wrapped = 1;
      end else begin
        just_wrapped = 0;
      end
    endfunction

    function void raw_pixel(bit [7:0] b);
      int unsigned w;
      int unsigned scan;
      w    = clamped_width();
      scan = 4 * ((w + 3) / 4);
      add_pixel(b, 0);
      advance_column();
      if (column >= scan) begin
        column = 0;
        row_base -= longint'(w);
      end
    endfunction

    // Returns 1 on end-of-bitmap
    function bit rle_decode(bit [7:0] b);
      int unsigned w;
      w = clamped_width();
      case (phase)
        PH_CMD: begin
          first_code = b;
          phase = PH_CODE;
        end
        PH_CODE: begin
          phase = PH_CMD;
          if (first_code != 0) begin
            for (int i = 0; i < first_code; i++) rle_pixel(b, 1);
          end else if (b == ESC_EOL) begin
            // skip the end-of-line that directly follows a wrap
            if (!just_wrapped) begin
              column = 0;
              row_base -= longint'(w);
            end
          end else if (b == ESC_EOB) begin
            return 1;
          end else if (b == ESC_DELTA) begin
            phase = PH_DX;
          end else begin
            pending_count = b;
            pad_pending   = b[0];
            phase         = PH_LIT;
          end
        end
        PH_DX: begin
          column += b;
          if (column > 32'hFFFF) column = 32'hFFFF;
          phase = PH_DY;
        end
        PH_DY: begin
          row_base -= longint'(w) * longint'(b);
          phase = PH_CMD;
        end
        PH_LIT: begin
          rle_pixel(b, 0);
          if (pending_count > 0) pending_count--;
          if (pending_count == 0) phase = pad_pending ? PH_PAD : PH_CMD;
        end
        default: phase = PH_CMD;
      endcase
      return 0;
    endfunction

    function void note_byte(bit [7:0] b, bit first, bit last);
      bit    ending;
      bit    eob;
      fill_t f;
      seg_count = 0;
      ending    = 0;
      if (first) begin
        restart();
        if (row_base < 0) begin
          phase  = PH_DONE;
          ending = 1;
        end
      end else if (phase == PH_DONE) begin
        return;
      end
      if (phase != PH_DONE) begin
        eob = 0;
        if (rle_cfg) eob = rle_decode(b);
        else raw_pixel(b);
        if (eob || last || row_base < 0) begin
          phase  = PH_DONE;
          ending = 1;
        end
      end
      if (seg_count == 0) begin
        if (ending) begin
          f.addr  = 0;
          f.len   = 0;
          f.color = 0;
          f.done  = 1;
          f.last  = 1;
          expected_fills.push_back(f);
        end
        return;
      end
      for (int k = 0; k < seg_count; k++) begin
        f.addr  = seg_addr[k][23:0];
        f.len   = seg_len[k][7:0];
        f.color = seg_color[k];
        f.last  = (k == seg_count - 1);
        f.done  = f.last && ending;
        expected_fills.push_back(f);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR: %s", msg);
    endtask

    task check_segment(logic [OUT_W-1:0] data, logic done, logic last);
      fill_t f;
      if (expected_fills.size() == 0) begin
        report($sformatf("unexpected segment addr %h len %0d color %h done %b last %b",
                         data[23:0], data[31:24], data[39:32], done, last));
        return;
      end
      f = expected_fills.pop_front();
      if (data[23:0] !== f.addr || data[31:24] !== f.len || data[39:32] !== f.color ||
          done !== f.done || last !== f.last) begin
        report($sformatf({"segment got addr %h len %0d color %h done %b last %b, ",
                          "want addr %h len %0d color %h done %b last %b"},
                         data[23:0], data[31:24], data[39:32], done, last,
                         f.addr, f.len, f.color, f.done, f.last));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  fill_scoreboard fill_sb = new();

  bit no_idle;
  bit sink_hold;
  bit mark_first;
  int random_items;

  // Encoded run, odd absolute run with pad, run ending on the row edge,
  // end-of-line right after the wrap, delta past the row end, dropped
  // pixel that wraps, end-of-bitmap
  bit [7:0] rle_script [20] = '{
    8'h03, 8'h11, 8'h00, 8'h03, 8'hA0, 8'hB1, 8'hC2, 8'h7F, 8'h02, 8'h22,
    8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h01, 8'h33, 8'h00, 8'h01
  };

  bmp_rle8_pixel_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) fill_sb.note_byte(in_tdata, in_tuser, in_tlast);
    if (rst_n && out_tvalid && out_tready) fill_sb.check_segment(out_tdata, out_tuser, out_tlast);
  end

  function int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        sink_hold = 0;
        out_tready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input bit [7:0] b, input bit first, input bit last);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic put(input bit [7:0] b);
    send_byte(b, mark_first, 1'b0);
    mark_first = 0;
    random_items++;
  endtask

  task automatic cfg_push(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_sb.set_register(idx, val);
  endtask

  task automatic write_config(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h,
                              input bit m);
    cfg_push(REG_WIDTH, w);
    cfg_push(REG_HEIGHT, h);
    cfg_push(REG_MODE, {{(CFG_W-1){1'b0}}, m});
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every expected segment, then let the block settle
  task automatic drain_segments();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fill_sb.expected_fills.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One RLE8 command, mostly well formed, sometimes a stray byte
  task automatic rle_command();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
      put(n[7:0]);
      put(8'($urandom_range(0, 255)));
    end else if (r < 60) begin
      put(8'h00);
      put(ESC_EOL);
    end else if (r < 70) begin
      put(8'h00);
      put(ESC_DELTA);
      put(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 12)));
      put(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 2)));
    end else if (r < 88) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(3, 9);
      put(8'h00);
      put(n[7:0]);
      repeat (n) put(8'($urandom_range(0, 255)));
      if (n % 2 == 1) put(8'($urandom_range(0, 255)));
    end else if (r < 92) begin
      put(8'h00);
      put(ESC_EOB);
    end else begin
      put(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int          phase_no;
    int          r;
    bit [CFG_W-1:0] w_val;
    bit [CFG_W-1:0] h_val;
    bit          m_val;

    rst_n        = 0;
    in_tvalid    = 0;
    in_tdata     = 0;
    in_tuser     = 0;
    in_tlast     = 0;
    cfg_valid    = 0;
    cfg_index    = 0;
    cfg_data     = 0;
    no_idle      = 0;
    sink_hold    = 0;
    mark_first   = 0;
    random_items = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, raw: restart, extreme bytes, final byte, then an ignored byte
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    drain_segments();

    // Width below the floor, zero height: restart ends at once
    write_config(13'd0, 13'd0, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b0);
    drain_segments();

    write_config(13'd8, 13'd3, 1'b1);
    for (int i = 0; i < 20; i++) send_byte(rle_script[i], i == 0, 1'b0);
    drain_segments();

    for (phase_no = 0; random_items < RANDOM_ITEMS; phase_no++) begin
      if (phase_no == 0) begin
        write_config(13'h1FFF, 13'h1FFF, 1'b1);
        m_val = 1;
      end else if (phase_no == 1) begin
        write_config(13'd4096, 13'd4096, 1'b0);
        m_val = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) w_val = CFG_W'($urandom_range(8, 24));
        else if (r < 80) w_val = CFG_W'($urandom_range(0, 7));
        else if (r < 90) w_val = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
        else w_val = CFG_W'($urandom_range(0, 8191));
        r = $urandom_range(0, 99);
        if (r < 70) h_val = CFG_W'($urandom_range(1, 6));
        else if (r < 80) h_val = '0;
        else if (r < 90) h_val = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
        else h_val = CFG_W'($urandom_range(0, 8191));
        m_val = ($urandom_range(0, 99) < 65);
        write_config(w_val, h_val, m_val);
      end
      // hold the receiver off while the sender keeps offering
      if (phase_no == 0) sink_hold = 1;
      no_idle = (phase_no % 4 == 1);
      // without a restart, decoding continues from the current state
      mark_first = (phase_no < 2) || ($urandom_range(0, 99) < 80);
      if (m_val) repeat ($urandom_range(3, 8)) rle_command();
      else repeat ($urandom_range(4, 30)) put(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 40) begin
        send_byte(8'($urandom_range(0, 255)), mark_first, 1'b1);
        mark_first = 0;
        random_items++;
      end
      drain_segments();
    end

    if (fill_sb.errors == 0 && fill_sb.expected_fills.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
